/* hdl/nsct_pkg.sv */
`default_nettype none
package nsct_pkg;

  // Sizes of the tag store and of the word fields
  localparam int ADDR_W   = 32;
  localparam int TAG_W    = 32;
  localparam int CNT_W    = 32;
  localparam int MAX_SETS = 256;
  localparam int MAX_WAYS = 8;
  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WAY_W    = 3;

  // Configuration register widths
  localparam int OFS_W    = 5;
  localparam int IDX_W    = 4;
  localparam int WAYS_W   = 4;

  // APB side
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 4;

  // Largest usable index width (log2 of the number of sets)
  localparam logic [IDX_W-1:0]  MAX_INDEX_BITS = IDX_W'(SET_W);
  localparam logic [WAYS_W-1:0] MAX_WAYS_CFG   = WAYS_W'(MAX_WAYS);

  // Register reset values
  localparam logic [OFS_W-1:0]  OFS_RESET  = OFS_W'(4);
  localparam logic [IDX_W-1:0]  IDX_RESET  = IDX_W'(8);
  localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(8);

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_INDEX  = 2'd1,
    REG_WAYS   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [OFS_W-1:0]  offset_bits;
    logic [IDX_W-1:0]  index_bits;
    logic [WAYS_W-1:0] ways_in_use;
  } cfg_t;

  // One set: per-way valid and NRU bits plus the tags
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            nru;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
  } row_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
    row_t             row;
  } wr_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic [CNT_W-1:0] miss_total;
  } result_t;

endpackage
`default_nettype wire

/* hdl/nsct_if.sv */
`default_nettype none
// Address word channel
interface nsct_req_if;
  import nsct_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// Lookup result word channel
interface nsct_rsp_if;
  import nsct_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] way;
  logic [CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output way, output miss_total, input ready);
  modport sink   (input valid, input hit, input way, input miss_total, output ready);
endinterface
`default_nettype wire

/* hdl/nsct_cfg.sv */
`default_nettype none
module nsct_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nsct_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [nsct_pkg::PDATA_W-1:0]  pwdata,
  output logic      [nsct_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output nsct_pkg::cfg_t                     cfg
);
  import nsct_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= OFS_RESET;
      cfg.index_bits  <= IDX_RESET;
      cfg.ways_in_use <= WAYS_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_OFFSET: cfg.offset_bits <= pwdata[OFS_W-1:0];
        REG_INDEX:  cfg.index_bits  <= pwdata[IDX_W-1:0];
        REG_WAYS:   cfg.ways_in_use <= pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_OFFSET: prdata = PDATA_W'(cfg.offset_bits);
      REG_INDEX:  prdata = PDATA_W'(cfg.index_bits);
      REG_WAYS:   prdata = PDATA_W'(cfg.ways_in_use);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/nsct_tag_ram.sv */
`default_nettype none
module nsct_tag_ram (
  input  wire logic                        clk,
  input  wire nsct_pkg::wr_t               wr,
  input  wire logic                        re,
  input  wire logic [nsct_pkg::SET_W-1:0]  raddr,
  output nsct_pkg::row_t                   rdata
);
  import nsct_pkg::*;

  // One row per set, all ways side by side
  row_t mem [MAX_SETS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.row;
    end
  end

  // Registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/nsct_lookup.sv */
`default_nettype none
module nsct_lookup (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nsct_pkg::cfg_t              cfg,
  input  wire logic                        commit,
  input  wire logic [nsct_pkg::SET_W-1:0]  set,
  input  wire logic [nsct_pkg::TAG_W-1:0]  tag,
  input  wire nsct_pkg::row_t              rd_row,
  output nsct_pkg::wr_t                    wr,
  output nsct_pkg::result_t                res
);
  import nsct_pkg::*;

  logic [MAX_SETS-1:0] row_valid;
  logic                fwd_valid;
  logic [SET_W-1:0]    fwd_set;
  row_t                fwd_row;
  logic [CNT_W-1:0]    miss_cnt;
  logic [CNT_W-1:0]    miss_cnt_next;

  logic [WAYS_W-1:0]   ways_c;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] cand;
  row_t                row;
  row_t                new_row;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    cand_way;
  logic [WAY_W-1:0]    pick;

  // Clamp the way count to 1..MAX_WAYS
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways_c = WAYS_W'(1);
    end else if (cfg.ways_in_use > MAX_WAYS_CFG) begin
      ways_c = MAX_WAYS_CFG;
    end else begin
      ways_c = cfg.ways_in_use;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WAYS_W'(w) < ways_c);
    end
  end

  // Current view of the set: last write wins, untouched rows read as reset
  always_comb begin
    if (fwd_valid && fwd_set == set) begin
      row = fwd_row;
    end else if (row_valid[set]) begin
      row = rd_row;
    end else begin
      row       = rd_row;
      row.valid = '0;
      row.nru   = '1;
    end
  end

  // Tag compare and lowest-way priority picks
  always_comb begin
    hit_vec  = '0;
    hit_way  = '0;
    cand_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w] = in_use[w] && row.valid[w] && (row.tags[w] == tag);
    end
    cand = row.nru & in_use;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (cand[w])    cand_way = WAY_W'(w);
    end
    hit = |hit_vec;
  end

  // Row update: touch on hit, fill the NRU victim on miss
  always_comb begin
    new_row = row;
    if (hit) begin
      pick = hit_way;
      new_row.nru[pick] = 1'b0;
    end else begin
      if (cand == '0) begin
        new_row.nru = row.nru | in_use;
        pick = '0;
      end else begin
        pick = cand_way;
      end
      new_row.tags[pick]  = tag;
      new_row.valid[pick] = 1'b1;
      new_row.nru[pick]   = 1'b0;
    end
  end

  // Saturating miss count
  assign miss_cnt_next = (hit || miss_cnt == '1) ? miss_cnt : miss_cnt + CNT_W'(1);

  assign wr.en           = commit;
  assign wr.set          = set;
  assign wr.row          = new_row;
  assign res.hit         = hit;
  assign res.way         = pick;
  assign res.miss_total  = miss_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
      miss_cnt  <= '0;
    end else if (commit) begin
      row_valid[set] <= 1'b1;
      fwd_valid      <= 1'b1;
      miss_cnt       <= miss_cnt_next;
    end
  end

  // Forwarded copy of the last row written
  always_ff @(posedge clk) begin
    if (commit) begin
      fwd_set <= set;
      fwd_row <= new_row;
    end
  end

`ifndef NO_ASSERTIONS
  // The chosen way is always one of the ways in use
  a_way_in_use: assert property (@(posedge clk) disable iff (rst)
    commit |-> ({1'b0, res.way} < ways_c))
    else $error("picked way beyond ways in use");

  // The written line ends valid and recently used
  a_line_touched: assert property (@(posedge clk) disable iff (rst)
    commit |-> (wr.row.valid[res.way] && !wr.row.nru[res.way]))
    else $error("written line not valid or NRU bit still set");

  // Miss count never decreases outside reset
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (miss_cnt >= $past(miss_cnt)))
    else $error("miss count decreased");

  // A forwarded row always belongs to a set already marked written
  a_fwd_marked: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> row_valid[fwd_set])
    else $error("forwarded set not marked written");
`endif

endmodule
`default_nettype wire

/* hdl/nru_set_assoc_cache_tags.sv */
// Tag store of a set-associative cache with not-recently-used replacement.
//
// req carries one address word per access; rsp returns one word per access
// with hit, the way that hit or was filled, and the saturating miss count.
// The user must write the settings over APB (offset_bits 0x0, index_bits
// 0x4, ways_in_use 0x8) only while no access is in flight (not enforced).
//
// An accepted req word is held in the lookup stage register and its result
// in the output register that drives rsp valid. The set row is read from a
// one-port-read synchronous memory in the accept cycle and updated and
// written back when the access leaves the lookup stage; a row written back
// is forwarded to the access that follows. While rsp is not stalled, one
// access per cycle is sustained, with back to back hits on the same set.
//
// Reset marks every set as untouched (all lines invalid, NRU bits set) at
// once through a per-set flag, clears the miss count and loads the register
// defaults; no clearing pass is needed. A stalled rsp holds its word; the
// lookup stage holds behind it and req.ready drops only when both are full.
`default_nettype none
module nru_set_assoc_cache_tags (
  input  wire logic                          clk,
  input  wire logic                          rst,
  nsct_req_if.sink                           req,
  nsct_rsp_if.source                         rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nsct_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [nsct_pkg::PDATA_W-1:0]  pwdata,
  output logic      [nsct_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import nsct_pkg::*;

  cfg_t              cfg;
  wr_t               wr;
  row_t              rd_row;
  result_t           res;

  logic              req_acc;
  logic [ADDR_W-1:0] above;
  logic [IDX_W-1:0]  ib;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;

  logic              s1_valid;
  logic [SET_W-1:0]  s1_set;
  logic [TAG_W-1:0]  s1_tag;
  logic              s1_adv;

  logic              out_valid;
  logic              out_hit;
  logic [WAY_W-1:0]  out_way;
  logic [CNT_W-1:0]  out_miss;

  nsct_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Address split: drop offset, take set index, rest is the tag
  always_comb begin
    ib     = (cfg.index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : cfg.index_bits;
    above  = req.address >> cfg.offset_bits;
    set_in = above[SET_W-1:0] & ~({SET_W{1'b1}} << ib);
    tag_in = TAG_W'(above >> ib);
  end

  // Handshakes
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign req_acc   = req.valid && req.ready;

  nsct_tag_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .re    (req_acc),
    .raddr (set_in),
    .rdata (rd_row)
  );

  nsct_lookup u_lookup (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .commit (s1_adv),
    .set    (s1_set),
    .tag    (s1_tag),
    .rd_row (rd_row),
    .wr     (wr),
    .res    (res)
  );

  // Lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_set <= set_in;
      s1_tag <= tag_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit  <= res.hit;
      out_way  <= res.way;
      out_miss <= res.miss_total;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.way        = out_way;
  assign rsp.miss_total = out_miss;

`ifndef NO_ASSERTIONS
  // No new word enters while the lookup stage is held
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !req_acc)
    else $error("word accepted into a held lookup stage");

  // A held result word is not overwritten
  a_out_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !s1_adv)
    else $error("pending result overwritten");

  // Every accepted word reaches the lookup stage
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> s1_valid)
    else $error("accepted word lost before lookup");
`endif

endmodule
`default_nettype wire
